>>> hw/rtl/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg
// Shared types and constants for the perfect square stream filter.
// ----------------------------------------------------------------------------
`default_nettype none

package psf_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned SQV_W  = 31;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned CAP_W  = 16;

    localparam int unsigned ROOT_W = DATA_W / 2;
    localparam int unsigned REM_W  = ROOT_W + 1;
    localparam int unsigned ITER   = DATA_W / 2;
    localparam int unsigned ITER_W = $clog2(ITER);

    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    localparam longint unsigned MAX_COUNT = 64'd65535;
    localparam logic [CNT_W-1:0] COUNT_LIMIT =
        (MAX_COUNT > 64'h0000_0000_0000_FFFF) ? {CNT_W{1'b1}} : CNT_W'(MAX_COUNT);

    localparam logic KIND_SQUARE  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
        logic update;
        logic clear;
        logic kind;
    } psf_cmd_t;

    typedef struct packed {
        logic last;
        logic square;
        logic below_cap;
    } psf_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/psf_in_if.sv
// ----------------------------------------------------------------------------
// psf_in_if
// Input channel: one signed sample and its end-of-sequence marker per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface psf_in_if;

    logic                                valid;
    logic                                ready;
    logic signed [psf_pkg::DATA_W-1:0]   value;
    logic                                last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);

endinterface

`default_nettype wire

>>> hw/rtl/psf_out_if.sv
// ----------------------------------------------------------------------------
// psf_out_if
// Output channel: passed squares and end-of-sequence summaries.
// ----------------------------------------------------------------------------
`default_nettype none

interface psf_out_if;

    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [psf_pkg::SQV_W-1:0]    square_value;
    logic [psf_pkg::CNT_W-1:0]    square_count;
    logic                         status;
    logic                         last_out;

    modport source (output valid, output kind, output square_value, output square_count,
                    output status, output last_out, input ready);
    modport sink   (input valid, input kind, input square_value, input square_count,
                    input status, input last_out, output ready);

endinterface

`default_nettype wire

>>> hw/rtl/psf_ctrl.sv
// ----------------------------------------------------------------------------
// psf_ctrl
// Sequencer: takes a request, runs the root iterations, then emits the square
// and/or summary result, if any.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire psf_pkg::psf_stat_t  stat,
    output psf_pkg::psf_cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DECIDE,
        ST_SEND_SQ,
        ST_SEND_SUM
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [psf_pkg::ITER_W-1:0]   cnt_reg;
    logic [psf_pkg::ITER_W-1:0]   cnt_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_SEND_SQ) || (state_reg == ST_SEND_SUM);

    assign cmd.load   = in_valid && in_ready;
    assign cmd.step   = (state_reg == ST_CALC);
    assign cmd.update = (state_reg == ST_DECIDE);
    assign cmd.clear  = (state_reg == ST_SEND_SUM) && out_ready;
    assign cmd.kind   = (state_reg == ST_SEND_SUM) ? psf_pkg::KIND_SUMMARY
                                                   : psf_pkg::KIND_SQUARE;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CALC;
                    cnt_next   = psf_pkg::ITER_W'(psf_pkg::ITER - 1);
                end
            end
            ST_CALC:
            begin
                if (cnt_reg == '0)
                    state_next = ST_DECIDE;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DECIDE:
            begin
                if (stat.square && stat.below_cap)
                    state_next = ST_SEND_SQ;
                else if (stat.last)
                    state_next = ST_SEND_SUM;
                else
                    state_next = ST_IDLE;
            end
            ST_SEND_SQ:
            begin
                if (out_ready)
                    state_next = stat.last ? ST_SEND_SUM : ST_IDLE;
            end
            ST_SEND_SUM:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/psf_datapath.sv
// ----------------------------------------------------------------------------
// psf_datapath
// Sample hold, two-bit-per-step integer square root, square counter and
// capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_datapath #(
    parameter longint unsigned MAX_COUNT = psf_pkg::MAX_COUNT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [psf_pkg::CAP_W-1:0]      cfg_wdata,
    input  wire logic [psf_pkg::DATA_W-1:0]     in_value,
    input  wire logic                           in_last,
    input  wire psf_pkg::psf_cmd_t              cmd,
    output psf_pkg::psf_stat_t                  stat,
    output logic [psf_pkg::SQV_W-1:0]           square_value,
    output logic [psf_pkg::CNT_W-1:0]           square_count,
    output logic                                status
);

    localparam logic [psf_pkg::CNT_W-1:0] COUNT_LIMIT =
        (MAX_COUNT > 64'h0000_0000_0000_FFFF) ? {psf_pkg::CNT_W{1'b1}}
                                               : psf_pkg::CNT_W'(MAX_COUNT);

    logic [psf_pkg::CAP_W-1:0]    capacity_reg;
    logic [psf_pkg::CNT_W-1:0]    found_reg;
    logic [psf_pkg::CNT_W-1:0]    found_next;

    logic [psf_pkg::DATA_W-1:0]   value_reg;
    logic                         last_reg;
    logic [psf_pkg::DATA_W-1:0]   rad_reg;
    logic [psf_pkg::REM_W-1:0]    rem_reg;
    logic [psf_pkg::ROOT_W-1:0]   root_reg;

    logic [psf_pkg::REM_W+1:0]    rem_sh;
    logic [psf_pkg::REM_W+1:0]    trial;
    logic [psf_pkg::REM_W+1:0]    diff;
    logic                         ge;

    assign rem_sh = {rem_reg, rad_reg[psf_pkg::DATA_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = (rem_sh >= trial);

    assign stat.last      = last_reg;
    assign stat.square    = (value_reg != '0) && !value_reg[psf_pkg::DATA_W-1]
                            && (rem_reg == '0);
    assign stat.below_cap = (found_reg < capacity_reg);

    always_comb
    begin
        found_next = found_reg;
        if (cmd.clear)
            found_next = '0;
        else if (cmd.update && stat.square && (found_reg < COUNT_LIMIT))
            found_next = found_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= psf_pkg::CAP_RESET;
            found_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_wdata;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= in_value;
            last_reg  <= in_last;
            rad_reg   <= in_value;
            rem_reg   <= '0;
            root_reg  <= '0;
        end
        else if (cmd.step)
        begin
            rad_reg  <= {rad_reg[psf_pkg::DATA_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[psf_pkg::REM_W-1:0] : rem_sh[psf_pkg::REM_W-1:0];
            root_reg <= {root_reg[psf_pkg::ROOT_W-2:0], ge};
        end
    end

    assign square_value = (cmd.kind == psf_pkg::KIND_SUMMARY) ? '0
                                                              : value_reg[psf_pkg::SQV_W-1:0];
    assign square_count = (cmd.kind == psf_pkg::KIND_SUMMARY) ? found_reg : '0;
    assign status       = (cmd.kind == psf_pkg::KIND_SUMMARY) && (found_reg > capacity_reg);

endmodule

`default_nettype wire

>>> hw/rtl/perfect_square_filter_top.sv
// ----------------------------------------------------------------------------
// perfect_square_filter_top
// Passes strictly positive perfect squares from a stream, up to a capacity,
// and closes each sequence with a count summary.
//
// in_ch  : one request per sample (value, last_in), valid/ready handshake.
// out_ch : square results (kind 0) and summaries (kind 1, last_out 1).
// cfg    : cfg_we/cfg_wdata write the capacity register; write only when idle.
//
// A sample is taken only when the block is idle. The root unit resolves two
// bits per cycle through the whole sample, then a decision state picks the
// result. A sample with no result lets the next one in after the decision;
// each result adds a send state plus any stall. Results sit registered on
// out_ch until taken; while out_ch is stalled no new sample is accepted.
// A last sample that is a passed square gives the square result first, then
// the summary; the count then clears.
// Reset clears the count, sets capacity to 65535 and drops pending work.
// ----------------------------------------------------------------------------
`default_nettype none

module perfect_square_filter_top #(
    parameter longint unsigned MAX_COUNT = psf_pkg::MAX_COUNT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [psf_pkg::CAP_W-1:0]   cfg_wdata,
    psf_in_if.sink                           in_ch,
    psf_out_if.source                        out_ch
);

    psf_pkg::psf_cmd_t   cmd;
    psf_pkg::psf_stat_t  stat;

    psf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    psf_datapath #(
        .MAX_COUNT (MAX_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_value     (in_ch.value),
        .in_last      (in_ch.last_in),
        .cmd          (cmd),
        .stat         (stat),
        .square_value (out_ch.square_value),
        .square_count (out_ch.square_count),
        .status       (out_ch.status)
    );

    assign out_ch.kind     = cmd.kind;
    assign out_ch.last_out = (cmd.kind == psf_pkg::KIND_SUMMARY);

endmodule

`default_nettype wire
